// File: src/hpv_pkg.sv
// Shared types, constants and reject codes for the heartbeat packet validator.
package hpv_pkg;

    localparam logic [15:0] SIG_VALUE  = 16'hFFD6;
    localparam logic [7:0]  MSGVER_OK  = 8'h01;
    localparam logic [7:0]  OPCODE_PNP = 8'h81;
    localparam logic [15:0] PORT_OK    = 16'd10000;
    localparam logic [7:0]  HWVER_NEW  = 8'd3;
    localparam logic [7:0]  HWVER_OLD_MAX = 8'd2;
    localparam logic [4:0]  LEN_NEW    = 5'd24;
    localparam logic [4:0]  LEN_OLD    = 5'd2;
    localparam logic [4:0]  COUNT_MAX  = 5'd25;

    localparam logic [4:0] POS_SIG_HI  = 5'd0;
    localparam logic [4:0] POS_SIG_LO  = 5'd1;
    localparam logic [4:0] POS_MSGVER  = 5'd4;
    localparam logic [4:0] POS_OPCODE  = 5'd8;
    localparam logic [4:0] POS_TYPE    = 5'd16;
    localparam logic [4:0] POS_VERSION = 5'd17;
    localparam logic [4:0] POS_REV_LO  = 5'd18;
    localparam logic [4:0] POS_REV_HI  = 5'd19;
    localparam logic [4:0] POS_PORT_HI = 5'd20;
    localparam logic [4:0] POS_PORT_LO = 5'd21;

    typedef enum logic [3:0] {
        REJ_OK          = 4'd0,
        REJ_TOO_SHORT   = 4'd1,
        REJ_NEW_SIZE    = 4'd2,
        REJ_MSGVER      = 4'd3,
        REJ_OPCODE      = 4'd4,
        REJ_NEW_TYPEVER = 4'd5,
        REJ_PORT        = 4'd6,
        REJ_OLD_SIZE    = 4'd7,
        REJ_OLD_TYPEVER = 4'd8
    } reject_code_t;

    typedef struct packed {
        logic [4:0]  count;
        logic [15:0] signature;
        logic [7:0]  msg_version;
        logic [7:0]  opcode;
        logic [7:0]  type_byte;
        logic [7:0]  version_byte;
        logic [15:0] revision;
        logic [15:0] port;
    } fields_t;

    typedef struct packed {
        logic         accepted;
        reject_code_t reject_code;
        logic         new_format;
        logic [7:0]   device_type;
        logic [7:0]   hw_version;
        logic [15:0]  hw_revision;
    } result_t;

endpackage

// File: src/hpv_if.sv
// Valid/ready channel interfaces for datagram bytes and verdicts.
interface hpv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hpv_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [3:0]  reject_code;
    logic        new_format;
    logic [7:0]  device_type;
    logic [7:0]  hw_version;
    logic [15:0] hw_revision;

    modport source (output valid, output accepted, output reject_code, output new_format,
                    output device_type, output hw_version, output hw_revision,
                    input ready);
    modport sink (input valid, input accepted, input reject_code, input new_format,
                  input device_type, input hw_version, input hw_revision,
                  output ready);
endinterface

// File: src/hpv_capture.sv
// Byte counter and fixed-offset field capture registers.
module hpv_capture
    import hpv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       xfer,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output fields_t    fields_cap
);

    fields_t fields_reg;
    fields_t fields_next;

    always_comb
    begin
        fields_cap = fields_reg;
        case (fields_reg.count)
            POS_SIG_HI:  fields_cap.signature[15:8] = data_byte;
            POS_SIG_LO:  fields_cap.signature[7:0]  = data_byte;
            POS_MSGVER:  fields_cap.msg_version     = data_byte;
            POS_OPCODE:  fields_cap.opcode          = data_byte;
            POS_TYPE:    fields_cap.type_byte       = data_byte;
            POS_VERSION: fields_cap.version_byte    = data_byte;
            POS_REV_LO:  fields_cap.revision[7:0]   = data_byte;
            POS_REV_HI:  fields_cap.revision[15:8]  = data_byte;
            POS_PORT_HI: fields_cap.port[15:8]      = data_byte;
            POS_PORT_LO: fields_cap.port[7:0]       = data_byte;
            default: ;
        endcase
        fields_cap.count = (fields_reg.count < COUNT_MAX) ? fields_reg.count + 5'd1
                                                          : COUNT_MAX;
    end

    always_comb
    begin
        fields_next = fields_reg;
        if (xfer)
        begin
            fields_next = last_byte ? '0 : fields_cap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fields_reg <= '0;
        end
        else
        begin
            fields_reg <= fields_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        fields_reg.count <= COUNT_MAX)
        else $error("byte count past saturation");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && last_byte) |=> (fields_reg.count == 5'd0 && fields_reg.signature == 16'd0))
        else $error("capture state not cleared after last byte");

endmodule

// File: src/hpv_verdict.sv
// Verdict logic: format detection and first-failing-check reject code.
module hpv_verdict
    import hpv_pkg::*;
(
    input  fields_t fields,
    output result_t result
);

    logic is_new;

    assign is_new = (fields.signature == SIG_VALUE);

    always_comb
    begin
        result             = '0;
        result.reject_code = REJ_OK;
        if (fields.count < LEN_OLD)
        begin
            result.reject_code = REJ_TOO_SHORT;
        end
        else if (is_new)
        begin
            result.new_format  = 1'b1;
            result.device_type = fields.type_byte;
            result.hw_version  = fields.version_byte;
            result.hw_revision = fields.revision;
            if (fields.count != LEN_NEW)
                result.reject_code = REJ_NEW_SIZE;
            else if (fields.msg_version != MSGVER_OK)
                result.reject_code = REJ_MSGVER;
            else if (fields.opcode != OPCODE_PNP)
                result.reject_code = REJ_OPCODE;
            else if (!(fields.type_byte == 8'd0 && fields.version_byte == HWVER_NEW))
                result.reject_code = REJ_NEW_TYPEVER;
            else if (fields.port != PORT_OK)
                result.reject_code = REJ_PORT;
        end
        else
        begin
            result.device_type = fields.signature[15:8];
            result.hw_version  = fields.signature[7:0];
            if (fields.count != LEN_OLD)
                result.reject_code = REJ_OLD_SIZE;
            else if (!(fields.signature[15:8] == 8'd0 &&
                       fields.signature[7:0] <= HWVER_OLD_MAX))
                result.reject_code = REJ_OLD_TYPEVER;
        end
        result.accepted = (result.reject_code == REJ_OK);
    end

endmodule

// File: src/hpv_out_buf.sv
// Result register with a skid stage toward the verdict channel.
module hpv_out_buf
    import hpv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    ready,
    hpv_out_if.source out_ch
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    out_xfer;

    assign out_xfer = out_valid_reg && out_ch.ready;
    assign ready    = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg && out_xfer)
        begin
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            if (!out_valid_reg || out_xfer)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.accepted    = out_data_reg.accepted;
    assign out_ch.reject_code = out_data_reg.reject_code;
    assign out_ch.new_format  = out_data_reg.new_format;
    assign out_ch.device_type = out_data_reg.device_type;
    assign out_ch.hw_version  = out_data_reg.hw_version;
    assign out_ch.hw_revision = out_data_reg.hw_revision;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while result register empty");

    a_accept_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.accepted == (out_data_reg.reject_code == REJ_OK)))
        else $error("accepted flag disagrees with reject code");

    a_old_no_revision: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.new_format) |-> (out_data_reg.hw_revision == 16'd0))
        else $error("old-form verdict carries a revision");

endmodule

// File: src/heartbeat_packet_validator_top.sv
// Top level of the heartbeat packet validator.
// Usage:
//   in_ch  carries one datagram byte per transfer (data_byte) and last_byte
//          marking the final byte. Bytes are counted and fields captured at
//          fixed offsets; the count saturates at 25.
//   out_ch carries one verdict per datagram: accepted, reject_code,
//          new_format, device_type, hw_version and hw_revision.
// Throughput: one byte per cycle while in_ch.ready is high, set by the
//   single capture/verdict stage. The verdict of the last byte is registered
//   in the result register, or in the skid stage while that one is held.
// Stall: a two-entry output (result register plus skid stage) keeps in_ch
//   ready while one verdict waits; in_ch.ready drops only when both entries
//   hold verdicts, and rises the cycle after out_ch takes one.
// Reset: rst_n clears the byte count, captured fields and both output
//   entries; the next byte is taken as byte 0 of a new datagram.
module heartbeat_packet_validator_top
    import hpv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    hpv_in_if.sink      in_ch,
    hpv_out_if.source   out_ch
);

    fields_t fields_cap;
    result_t result;
    logic    in_xfer;
    logic    buf_ready;

    assign in_ch.ready = buf_ready;
    assign in_xfer     = in_ch.valid && buf_ready;

    hpv_capture u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .xfer       (in_xfer),
        .data_byte  (in_ch.data_byte),
        .last_byte  (in_ch.last_byte),
        .fields_cap (fields_cap)
    );

    hpv_verdict u_verdict (
        .fields (fields_cap),
        .result (result)
    );

    hpv_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_xfer && in_ch.last_byte),
        .push_data (result),
        .ready     (buf_ready),
        .out_ch    (out_ch)
    );

endmodule
